[rtl/core/tile_gid_to_atlas_quad_core_defines.svh]
// Assertion macros shared by the tile quad core RTL.
`ifndef TILE_GID_TO_ATLAS_QUAD_CORE_DEFINES_SVH
`define TILE_GID_TO_ATLAS_QUAD_CORE_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger.
`define TGAQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define TGAQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/tgaq_pkg.sv]
// Shared types, constants and helpers of the tile quad core.
package tgaq_pkg;

  // Map and atlas constants
  localparam int MAP_DIM      = 1024;
  localparam int ATLAS_MARGIN = 0;

  // Divider geometry: local index padded to QUO_W, DIV_STEPS bits per stage
  localparam int LOCAL_W    = 13;
  localparam int QUO_W      = 16;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = QUO_W / DIV_STEPS;
  localparam int REM_W      = 9;

  // Texel coordinate limit
  localparam int TEX_W = 21;
  localparam logic [23:0] TEX_MAX = 24'd2097151;

  typedef enum logic [2:0] {
    REG_FIRST_ID           = 3'd0,
    REG_ID_COUNT           = 3'd1,
    REG_ATLAS_COLUMNS      = 3'd2,
    REG_ATLAS_TILE_WIDTH   = 3'd3,
    REG_ATLAS_TILE_HEIGHT  = 3'd4,
    REG_ATLAS_SPACING      = 3'd5,
    REG_SCREEN_TILE_WIDTH  = 3'd6,
    REG_SCREEN_TILE_HEIGHT = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] first_id;
    logic [12:0] id_count;
    logic [8:0]  atlas_columns;
    logic [8:0]  atlas_tile_width;
    logic [8:0]  atlas_tile_height;
    logic [3:0]  atlas_spacing;
    logic [8:0]  screen_tile_width;
    logic [8:0]  screen_tile_height;
  } cfg_t;

  // Screen products carried beside the divider
  typedef struct packed {
    logic [18:0] st;
    logic [18:0] sl;
  } side_t;

  typedef struct packed {
    logic [20:0] tex_bottom;
    logic [20:0] tex_right;
    logic [20:0] tex_top;
    logic [20:0] tex_left;
    logic [18:0] screen_bottom;
    logic [18:0] screen_right;
    logic [17:0] screen_top;
    logic [17:0] screen_left;
  } quad_t;

  // Clamp a texel coordinate to the field range
  function automatic logic [TEX_W-1:0] sat_tex(input logic [23:0] v);
    logic [TEX_W-1:0] r;
    r = (v > TEX_MAX) ? TEX_MAX[TEX_W-1:0] : v[TEX_W-1:0];
    return r;
  endfunction

endpackage

[rtl/core/tgaq_cfg.sv]
// Configuration register file of the tile quad core.
module tgaq_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  logic [2:0]          wr_index,
  input  logic [15:0]         wr_data,
  output tgaq_pkg::cfg_t      cfg
);

  // Always take a write request
  assign wr_ready = 1'b1;

  // Load defaults on reset, update one register per request
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_id           <= 16'd1;
      cfg.id_count           <= 13'd0;
      cfg.atlas_columns      <= 9'd1;
      cfg.atlas_tile_width   <= 9'd16;
      cfg.atlas_tile_height  <= 9'd16;
      cfg.atlas_spacing      <= 4'd0;
      cfg.screen_tile_width  <= 9'd16;
      cfg.screen_tile_height <= 9'd16;
    end else if (wr_valid && wr_ready) begin
      case (tgaq_pkg::reg_idx_t'(wr_index))
        tgaq_pkg::REG_FIRST_ID:           cfg.first_id           <= wr_data;
        tgaq_pkg::REG_ID_COUNT:           cfg.id_count           <= wr_data[12:0];
        tgaq_pkg::REG_ATLAS_COLUMNS:      cfg.atlas_columns      <= wr_data[8:0];
        tgaq_pkg::REG_ATLAS_TILE_WIDTH:   cfg.atlas_tile_width   <= wr_data[8:0];
        tgaq_pkg::REG_ATLAS_TILE_HEIGHT:  cfg.atlas_tile_height  <= wr_data[8:0];
        tgaq_pkg::REG_ATLAS_SPACING:      cfg.atlas_spacing      <= wr_data[3:0];
        tgaq_pkg::REG_SCREEN_TILE_WIDTH:  cfg.screen_tile_width  <= wr_data[8:0];
        tgaq_pkg::REG_SCREEN_TILE_HEIGHT: cfg.screen_tile_height <= wr_data[8:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/tgaq_div_stage.sv]
// One pipeline stage of the restoring divider for the atlas index.
`include "tile_gid_to_atlas_quad_core_defines.svh"

module tgaq_div_stage #(
  parameter int STEPS  = 4,
  parameter int SIDE_W = 38
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [tgaq_pkg::REM_W-1:0] in_rem,
  input  logic [tgaq_pkg::QUO_W-1:0] in_work,
  input  logic [SIDE_W-1:0]          in_side,
  input  logic [tgaq_pkg::REM_W-1:0] divisor,
  output logic                       out_valid,
  output logic [tgaq_pkg::REM_W-1:0] out_rem,
  output logic [tgaq_pkg::QUO_W-1:0] out_work,
  output logic [SIDE_W-1:0]          out_side
);

  logic [tgaq_pkg::REM_W-1:0] rem_c;
  logic [tgaq_pkg::QUO_W-1:0] work_c;
  logic [tgaq_pkg::REM_W:0]   trial;

  // Shift dividend bits out of the top, quotient bits in at the bottom
  always_comb begin
    rem_c  = in_rem;
    work_c = in_work;
    trial  = '0;
    for (int i = 0; i < STEPS; i++) begin
      trial = {rem_c, work_c[tgaq_pkg::QUO_W-1]};
      if (trial >= {1'b0, divisor}) begin
        trial  = trial - {1'b0, divisor};
        work_c = {work_c[tgaq_pkg::QUO_W-2:0], 1'b1};
      end else begin
        work_c = {work_c[tgaq_pkg::QUO_W-2:0], 1'b0};
      end
      rem_c = trial[tgaq_pkg::REM_W-1:0];
    end
  end

  // Advance the stage when the pipeline moves
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= rem_c;
      out_work <= work_c;
      out_side <= in_side;
    end
  end

  // Partial remainder always stays below the divisor
  `TGAQ_ASSERT_SAME(a_rem_below_div, out_valid, out_rem < divisor, "remainder out of range")

endmodule

[rtl/core/tgaq_skid.sv]
// Output register with a skid entry for the quad stream.
module tgaq_skid (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tgaq_pkg::quad_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output tgaq_pkg::quad_t out_data
);

  logic            skid_valid;
  tgaq_pkg::quad_t skid_data;

  // Take a request only while the skid entry is free
  assign in_ready = !skid_valid;

  // Control: refill the output from skid first, park on a stall
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid && in_ready) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_valid) begin
        out_data <= in_data;
      end
    end else if (in_valid && in_ready) begin
      skid_data <= in_data;
    end
  end

endmodule

[rtl/core/tile_gid_to_atlas_quad_core.sv]
// Throughput: one request per cycle while the output skid entry is free; the rate
// is set by the seven-stage pipe (range check, four divider stages of four quotient
// bits, multiply, add), which holds as a whole while the skid entry is occupied.
// Out-of-range ids and cells are dropped in the first stage and give no result.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
`include "tile_gid_to_atlas_quad_core_defines.svh"

module tile_gid_to_atlas_quad_core (
  input  logic         clk,
  input  logic         rst,
  // Input cells
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,  // cell_col[9:0], cell_row[19:10], tile_id[35:20], 0
  // Output quads
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [159:0] m_axis_tdata,  // screen_left, screen_top, screen_right,
                                      // screen_bottom, tex_left, tex_top,
                                      // tex_right, tex_bottom, 0 (low bit up)
  // Configuration writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  localparam int SIDE_W = $bits(tgaq_pkg::side_t);

  tgaq_pkg::cfg_t cfg;

  logic [9:0]  cell_col;
  logic [9:0]  cell_row;
  logic [15:0] tile_id;
  logic [16:0] id_diff;
  logic        hit;
  logic        pipe_en;
  logic [tgaq_pkg::REM_W-1:0] divisor;

  logic                       s1_valid;
  logic [tgaq_pkg::QUO_W-1:0] s1_work;
  tgaq_pkg::side_t            s1_side;

  logic                       d_valid [0:tgaq_pkg::DIV_STAGES];
  logic [tgaq_pkg::REM_W-1:0] d_rem   [0:tgaq_pkg::DIV_STAGES];
  logic [tgaq_pkg::QUO_W-1:0] d_work  [0:tgaq_pkg::DIV_STAGES];
  logic [SIDE_W-1:0]          d_side  [0:tgaq_pkg::DIV_STAGES];

  logic [9:0]      pitch_w;
  logic [9:0]      pitch_h;
  logic            p1_valid;
  logic [18:0]     p1_u;
  logic [22:0]     p1_v;
  tgaq_pkg::side_t p1_side;

  logic [23:0]     u_m;
  logic [23:0]     v_m;
  logic [19:0]     sr_sum;
  logic [19:0]     sb_sum;
  tgaq_pkg::quad_t p2_quad_c;
  logic            p2_valid;
  tgaq_pkg::quad_t p2_quad;
  tgaq_pkg::quad_t out_quad;

  tgaq_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg_valid),
    .wr_ready (cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Unpack the request and check the id range and map bounds
  assign cell_col = s_axis_tdata[9:0];
  assign cell_row = s_axis_tdata[19:10];
  assign tile_id  = s_axis_tdata[35:20];
  assign id_diff  = {1'b0, tile_id} - {1'b0, cfg.first_id};
  assign hit      = !id_diff[16] && (id_diff[15:0] < {3'b000, cfg.id_count})
                    && ({1'b0, cell_col} < 11'(tgaq_pkg::MAP_DIM))
                    && ({1'b0, cell_row} < 11'(tgaq_pkg::MAP_DIM));

  // Hold the whole pipe while the output skid entry is occupied
  assign s_axis_tready = pipe_en;

  // Zero atlas columns act as one
  assign divisor = (cfg.atlas_columns == '0) ? 9'd1 : cfg.atlas_columns;

  // Stage 1: keep hits, form screen products
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pipe_en) begin
      s1_valid <= s_axis_tvalid && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_work    <= tgaq_pkg::QUO_W'(id_diff[tgaq_pkg::LOCAL_W-1:0]);
      s1_side.sl <= cell_col * cfg.screen_tile_width;
      s1_side.st <= cell_row * cfg.screen_tile_height;
    end
  end

  assign d_valid[0] = s1_valid;
  assign d_rem[0]   = '0;
  assign d_work[0]  = s1_work;
  assign d_side[0]  = s1_side;

  // Divider stages: local index by atlas columns
  for (genvar g = 0; g < tgaq_pkg::DIV_STAGES; g++) begin : g_div
    tgaq_div_stage #(
      .STEPS  (tgaq_pkg::DIV_STEPS),
      .SIDE_W (SIDE_W)
    ) u_div (
      .clk       (clk),
      .rst       (rst),
      .en        (pipe_en),
      .in_valid  (d_valid[g]),
      .in_rem    (d_rem[g]),
      .in_work   (d_work[g]),
      .in_side   (d_side[g]),
      .divisor   (divisor),
      .out_valid (d_valid[g+1]),
      .out_rem   (d_rem[g+1]),
      .out_work  (d_work[g+1]),
      .out_side  (d_side[g+1])
    );
  end

  // Scale atlas column and row by the tile pitch
  assign pitch_w = {1'b0, cfg.atlas_tile_width} + 10'(cfg.atlas_spacing);
  assign pitch_h = {1'b0, cfg.atlas_tile_height} + 10'(cfg.atlas_spacing);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (pipe_en) begin
      p1_valid <= d_valid[tgaq_pkg::DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      p1_u    <= d_rem[tgaq_pkg::DIV_STAGES] * pitch_w;
      p1_v    <= d_work[tgaq_pkg::DIV_STAGES][tgaq_pkg::LOCAL_W-1:0] * pitch_h;
      p1_side <= tgaq_pkg::side_t'(d_side[tgaq_pkg::DIV_STAGES]);
    end
  end

  // Add margin and tile size, clamp texels, wrap screen edges
  assign u_m    = 24'(p1_u) + 24'(tgaq_pkg::ATLAS_MARGIN);
  assign v_m    = 24'(p1_v) + 24'(tgaq_pkg::ATLAS_MARGIN);
  assign sr_sum = {1'b0, p1_side.sl} + 20'(cfg.screen_tile_width);
  assign sb_sum = {1'b0, p1_side.st} + 20'(cfg.screen_tile_height);

  always_comb begin
    p2_quad_c.screen_left   = p1_side.sl[17:0];
    p2_quad_c.screen_top    = p1_side.st[17:0];
    p2_quad_c.screen_right  = sr_sum[18:0];
    p2_quad_c.screen_bottom = sb_sum[18:0];
    p2_quad_c.tex_left      = tgaq_pkg::sat_tex(u_m);
    p2_quad_c.tex_top       = tgaq_pkg::sat_tex(v_m);
    p2_quad_c.tex_right     = tgaq_pkg::sat_tex(u_m + 24'(cfg.atlas_tile_width));
    p2_quad_c.tex_bottom    = tgaq_pkg::sat_tex(v_m + 24'(cfg.atlas_tile_height));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (pipe_en) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      p2_quad <= p2_quad_c;
    end
  end

  // Output register with skid entry
  tgaq_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p2_valid),
    .in_ready  (pipe_en),
    .in_data   (p2_quad),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_quad)
  );

  assign m_axis_tdata = {2'b00,
                         out_quad.tex_bottom, out_quad.tex_right,
                         out_quad.tex_top, out_quad.tex_left,
                         out_quad.screen_bottom, out_quad.screen_right,
                         out_quad.screen_top, out_quad.screen_left};

  // Clamped texel edges never cross
  `TGAQ_ASSERT_SAME(a_tex_order, m_axis_tvalid, (out_quad.tex_right >= out_quad.tex_left) && (out_quad.tex_bottom >= out_quad.tex_top), "texel rectangle inverted")
  // A stalled last stage keeps its request
  `TGAQ_ASSERT_NEXT(a_stall_hold, p2_valid && !pipe_en, p2_valid, "stalled request lost")
  // A request outside the range never enters the pipe
  `TGAQ_ASSERT_NEXT(a_drop_miss, s_axis_tvalid && s_axis_tready && !hit, !s1_valid, "miss entered pipe")
  // Nothing is presented right after reset
  `TGAQ_ASSERT_SAME(a_reset_quiet, $past(rst), !m_axis_tvalid && !p2_valid, "valid after reset")

endmodule
